/* src/rsi_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsi_pkg: shared types and constants of the ray/sphere intersection block
// Fixed-point widths, payload structs, register indexes and reset values.
// ----------------------------------------------------------------------------
package rsi_pkg;

    localparam int CW        = 32;          // coordinate width
    localparam int FB        = 16;          // fractional bits
    localparam int RW        = 31;          // radius and scale width
    localparam int CFG_IDX_W = 3;

    localparam int OC_W  = CW + 1;          // origin minus center
    localparam int PB_W  = CW + OC_W;       // dir * oc
    localparam int PQ_W  = 2 * OC_W;        // oc * oc
    localparam int B_W   = PB_W + 2;        // sum of three products
    localparam int Q_W   = PQ_W + 2;
    localparam int AB_W  = B_W;             // magnitude of b
    localparam int AB_L  = (AB_W + 1) / 2;
    localparam int AB_H  = AB_W - AB_L;
    localparam int BB_W  = 2 * AB_W;
    localparam int RS_W  = 2 * RW;          // scaled radius
    localparam int RS_H  = RS_W / 2;
    localparam int SR2_W = 2 * RS_W;
    localparam int D_W   = BB_W + 2;        // discriminant, even width
    localparam int RT_W  = D_W / 2;         // square root width
    localparam int REM_W = RT_W + 2;
    localparam int T_W   = RT_W + 1;        // -b - sqrt, signed
    localparam int TS_W  = T_W - FB;

    localparam logic [RW-1:0] RADIUS_RST = RW'(100 << FB);
    localparam logic [RW-1:0] SCALE_RST  = RW'(1 << FB);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CENTER_X = 3'd0,
        REG_CENTER_Y = 3'd1,
        REG_CENTER_Z = 3'd2,
        REG_RADIUS   = 3'd3,
        REG_SCALE    = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic signed [CW-1:0] origin_x;
        logic signed [CW-1:0] origin_y;
        logic signed [CW-1:0] origin_z;
        logic signed [CW-1:0] dir_x;
        logic signed [CW-1:0] dir_y;
        logic signed [CW-1:0] dir_z;
    } t_ray;

    typedef struct packed {
        logic                 hit;
        logic signed [CW-1:0] distance;
    } t_result;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        logic [CW-1:0]        value;
    } t_cfg_wr;

    // State handed from one square-root cell to the next.
    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [RT_W-1:0]  root;
        logic [D_W-1:0]   rad;
        logic             hit;
        logic [AB_W-1:0]  abs_b;
    } t_sq;

endpackage

/* src/rsi_stream_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsi_stream_if: valid/ready channel
// Carries one payload of type T per transfer.
// ----------------------------------------------------------------------------
interface rsi_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* src/ray_sphere_intersect.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_sphere_intersect: ray against configured sphere
// Streams one ray per cycle unless stalled; returns hit flag and nearer distance.
// ----------------------------------------------------------------------------
//
//   Channel  Dir  Payload                               Transfer when
//   i_ray    in   origin_x/y/z, dir_x/y/z (Q16.16)      valid && ready
//   o_res    out  hit, distance (Q16.16)                valid && ready
//   i_cfg    in   index (register), value               valid (ready is 1)
//
// One ray enters per cycle unless the pipeline is stalled; each result passes
// the dot-product and discriminant stages, 68 cells of the square-root chain
// (one root bit per cell), the final subtract and one output register. A
// radius or scale write reaches the discriminant stage through the registers
// of rsi_radius_sq. Reset restores center 0, radius 100.0 and scale 1.0 and
// empties the pipeline. A stalled output freezes the pipeline only once the
// next result is ready to land in the output register.
// ----------------------------------------------------------------------------
module ray_sphere_intersect (
    input  logic          i_clk,
    input  logic          i_rst_n,
    rsi_stream_if.sink    i_ray,
    rsi_stream_if.source  o_res,
    rsi_stream_if.sink    i_cfg
);
    localparam int CW   = rsi_pkg::CW;
    localparam int RW   = rsi_pkg::RW;
    localparam int RT_W = rsi_pkg::RT_W;

    // Sphere configuration registers.
    logic signed [CW-1:0] r_center_x, r_center_y, r_center_z;
    logic [RW-1:0]        r_radius, r_scale;
    logic [rsi_pkg::SR2_W-1:0] w_sr2;

    // Pipeline valid bits and the state handed along the square-root chain.
    logic                 w_v  [0:RT_W];
    rsi_pkg::t_sq         w_sq [0:RT_W];
    logic                 w_fin_valid;
    rsi_pkg::t_result     w_fin_res;
    logic                 w_en;

    rsi_pkg::t_result     r_out;
    logic                 r_out_valid;

    // Configuration is always accepted; unknown indexes are dropped.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x <= '0;
            r_center_y <= '0;
            r_center_z <= '0;
            r_radius   <= rsi_pkg::RADIUS_RST;
            r_scale    <= rsi_pkg::SCALE_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.data.index)
                rsi_pkg::REG_CENTER_X: r_center_x <= i_cfg.data.value;
                rsi_pkg::REG_CENTER_Y: r_center_y <= i_cfg.data.value;
                rsi_pkg::REG_CENTER_Z: r_center_z <= i_cfg.data.value;
                rsi_pkg::REG_RADIUS:   r_radius   <= i_cfg.data.value[RW-1:0];
                rsi_pkg::REG_SCALE:    r_scale    <= i_cfg.data.value[RW-1:0];
                default: begin
                end
            endcase
        end
    end

    // The whole pipeline moves together. It only has to stop when a finished
    // result is about to enter an output register that is still occupied.
    assign w_en        = !r_out_valid || o_res.ready || !w_fin_valid;
    assign i_ray.ready = w_en;

    rsi_radius_sq u_radius_sq (
        .i_clk    (i_clk),
        .i_radius (r_radius),
        .i_scale  (r_scale),
        .o_sr2    (w_sr2)
    );

    rsi_geom u_geom (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_valid    (i_ray.valid),
        .i_ray      (i_ray.data),
        .i_center_x (r_center_x),
        .i_center_y (r_center_y),
        .i_center_z (r_center_z),
        .i_sr2      (w_sr2),
        .o_valid    (w_v[0]),
        .o_sq       (w_sq[0])
    );

    // Square-root chain: each cell settles one bit of the floor root.
    for (genvar g = 0; g < RT_W; g++) begin : g_sqrt
        rsi_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_v[g]),
            .i_sq    (w_sq[g]),
            .o_valid (w_v[g+1]),
            .o_sq    (w_sq[g+1])
        );
    end

    rsi_finish u_finish (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_v[RT_W]),
        .i_sq    (w_sq[RT_W]),
        .o_valid (w_fin_valid),
        .o_res   (w_fin_res)
    );

    // Output register: holds a result until its transfer completes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en && w_fin_valid) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en && w_fin_valid) begin
            r_out <= w_fin_res;
        end
    end

    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

    // A miss never carries a distance.
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.hit |-> r_out.distance == '0)
        else $error("miss result with nonzero distance");

    // The chain advances one cell per enabled cycle.
    a_chain_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_en |=> w_v[1] == $past(w_v[0]))
        else $error("square-root chain lost or duplicated an item");

    // A finished floor root leaves a remainder of at most twice the root.
    a_root_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_v[RT_W] |-> w_sq[RT_W].rem <= {1'b0, w_sq[RT_W].root, 1'b0})
        else $error("square-root remainder out of range");
endmodule

/* src/rsi_radius_sq.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsi_radius_sq: squared scaled radius
// Free-running three-stage multiply of the radius registers.
// ----------------------------------------------------------------------------
module rsi_radius_sq (
    input  logic                          i_clk,
    input  logic [rsi_pkg::RW-1:0]        i_radius,
    input  logic [rsi_pkg::RW-1:0]        i_scale,
    output logic [rsi_pkg::SR2_W-1:0]     o_sr2
);
    localparam int RS_W  = rsi_pkg::RS_W;
    localparam int RS_H  = rsi_pkg::RS_H;
    localparam int SR2_W = rsi_pkg::SR2_W;

    logic [RS_W-1:0]  r_rs;
    logic [RS_W-1:0]  r_ll, r_lh, r_hh;
    logic [SR2_W-1:0] r_sr2;

    always_ff @(posedge i_clk) begin
        r_rs  <= RS_W'(i_radius) * RS_W'(i_scale);
        r_ll  <= RS_W'(r_rs[RS_H-1:0]) * RS_W'(r_rs[RS_H-1:0]);
        r_lh  <= RS_W'(r_rs[RS_W-1:RS_H]) * RS_W'(r_rs[RS_H-1:0]);
        r_hh  <= RS_W'(r_rs[RS_W-1:RS_H]) * RS_W'(r_rs[RS_W-1:RS_H]);
        // The cross term appears twice, hence one extra bit of shift.
        r_sr2 <= (SR2_W'(r_hh) << (2 * RS_H)) + (SR2_W'(r_lh) << (RS_H + 1))
               + SR2_W'(r_ll);
    end

    assign o_sr2 = r_sr2;
endmodule

/* src/rsi_geom.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsi_geom: dot products and discriminant
// Seven stages from the ray to b, b*b - c and the miss test.
// ----------------------------------------------------------------------------
module rsi_geom (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_valid,
    input  rsi_pkg::t_ray                     i_ray,
    input  logic signed [rsi_pkg::CW-1:0]     i_center_x,
    input  logic signed [rsi_pkg::CW-1:0]     i_center_y,
    input  logic signed [rsi_pkg::CW-1:0]     i_center_z,
    input  logic [rsi_pkg::SR2_W-1:0]         i_sr2,
    output logic                              o_valid,
    output rsi_pkg::t_sq                      o_sq
);
    localparam int CW   = rsi_pkg::CW;
    localparam int OC_W = rsi_pkg::OC_W;
    localparam int PB_W = rsi_pkg::PB_W;
    localparam int PQ_W = rsi_pkg::PQ_W;
    localparam int B_W  = rsi_pkg::B_W;
    localparam int Q_W  = rsi_pkg::Q_W;
    localparam int AB_W = rsi_pkg::AB_W;
    localparam int AB_L = rsi_pkg::AB_L;
    localparam int AB_H = rsi_pkg::AB_H;
    localparam int BB_W = rsi_pkg::BB_W;
    localparam int D_W  = rsi_pkg::D_W;

    logic signed [CW-1:0] w_org [3];
    logic signed [CW-1:0] w_dir [3];
    logic signed [CW-1:0] w_ctr [3];

    logic [6:0] r_valid;

    logic signed [OC_W-1:0] r1_oc  [3];
    logic signed [CW-1:0]   r1_dir [3];
    logic signed [PB_W-1:0] r2_pb  [3];
    logic signed [PQ_W-1:0] r2_pq  [3];
    logic signed [B_W-1:0]  r3_b;
    logic signed [Q_W-1:0]  r3_q;
    logic [AB_W-1:0]        r4_absb, r5_absb, r6_absb;
    logic                   r4_bpos, r5_bpos, r6_bpos;
    logic signed [Q_W-1:0]  r4_q, r5_q, r6_q;
    logic [2*AB_L-1:0]      r5_ll;
    logic [AB_W-1:0]        r5_lh;
    logic [2*AB_H-1:0]      r5_hh;
    logic [BB_W-1:0]        r6_bb;
    logic [D_W-1:0]         n_d;
    rsi_pkg::t_sq           r7_sq;

    assign w_org[0] = i_ray.origin_x;
    assign w_org[1] = i_ray.origin_y;
    assign w_org[2] = i_ray.origin_z;
    assign w_dir[0] = i_ray.dir_x;
    assign w_dir[1] = i_ray.dir_y;
    assign w_dir[2] = i_ray.dir_z;
    assign w_ctr[0] = i_center_x;
    assign w_ctr[1] = i_center_y;
    assign w_ctr[2] = i_center_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[5:0], i_valid};
        end
    end

    // Discriminant: b*b minus |oc|^2 moved up to 4*FB fraction bits, plus the
    // squared scaled radius.
    assign n_d = D_W'(r6_bb) - (D_W'(r6_q) << (2 * rsi_pkg::FB)) + D_W'(i_sr2);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r1_oc[i]  <= OC_W'(w_org[i]) - OC_W'(w_ctr[i]);
                r1_dir[i] <= w_dir[i];
                r2_pb[i]  <= PB_W'(r1_dir[i]) * PB_W'(r1_oc[i]);
                r2_pq[i]  <= PQ_W'(r1_oc[i]) * PQ_W'(r1_oc[i]);
            end
            r3_b <= B_W'(r2_pb[0]) + B_W'(r2_pb[1]) + B_W'(r2_pb[2]);
            r3_q <= Q_W'(r2_pq[0]) + Q_W'(r2_pq[1]) + Q_W'(r2_pq[2]);

            r4_absb <= r3_b[B_W-1] ? AB_W'(-r3_b) : AB_W'(r3_b);
            r4_bpos <= !r3_b[B_W-1] && (r3_b != '0);
            r4_q    <= r3_q;

            r5_ll   <= (2*AB_L)'(r4_absb[AB_L-1:0]) * (2*AB_L)'(r4_absb[AB_L-1:0]);
            r5_lh   <= AB_W'(r4_absb[AB_W-1:AB_L]) * AB_W'(r4_absb[AB_L-1:0]);
            r5_hh   <= (2*AB_H)'(r4_absb[AB_W-1:AB_L])
                     * (2*AB_H)'(r4_absb[AB_W-1:AB_L]);
            r5_absb <= r4_absb;
            r5_bpos <= r4_bpos;
            r5_q    <= r4_q;

            r6_bb   <= (BB_W'(r5_hh) << (2 * AB_L)) + (BB_W'(r5_lh) << (AB_L + 1))
                     + BB_W'(r5_ll);
            r6_absb <= r5_absb;
            r6_bpos <= r5_bpos;
            r6_q    <= r5_q;

            r7_sq.rem   <= '0;
            r7_sq.root  <= '0;
            r7_sq.rad   <= n_d;
            r7_sq.hit   <= !n_d[D_W-1] && !r6_bpos;
            r7_sq.abs_b <= r6_absb;
        end
    end

    assign o_valid = r_valid[6];
    assign o_sq    = r7_sq;
endmodule

/* src/rsi_sqrt_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsi_sqrt_cell: one step of the square-root chain
// Brings down two radicand bits and settles one root bit.
// ----------------------------------------------------------------------------
module rsi_sqrt_cell (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_en,
    input  logic         i_valid,
    input  rsi_pkg::t_sq i_sq,
    output logic         o_valid,
    output rsi_pkg::t_sq o_sq
);
    localparam int RT_W  = rsi_pkg::RT_W;
    localparam int REM_W = rsi_pkg::REM_W;
    localparam int D_W   = rsi_pkg::D_W;

    logic [REM_W-1:0] w_rem_sh;
    logic [REM_W-1:0] w_trial;
    logic             w_ge;
    rsi_pkg::t_sq     n_sq;
    rsi_pkg::t_sq     r_sq;
    logic             r_valid;

    assign w_rem_sh = {i_sq.rem[RT_W-1:0], i_sq.rad[D_W-1 -: 2]};
    assign w_trial  = {i_sq.root, 2'b01};
    assign w_ge     = (w_rem_sh >= w_trial);

    always_comb begin
        n_sq       = i_sq;
        n_sq.rem   = w_ge ? (w_rem_sh - w_trial) : w_rem_sh;
        n_sq.root  = {i_sq.root[RT_W-2:0], w_ge};
        n_sq.rad   = i_sq.rad << 2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sq <= n_sq;
        end
    end

    assign o_valid = r_valid;
    assign o_sq    = r_sq;
endmodule

/* src/rsi_finish.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsi_finish: nearer root and saturation
// Forms -b - sqrt, floors away its low FB fraction bits and clamps to the output.
// ----------------------------------------------------------------------------
module rsi_finish (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  rsi_pkg::t_sq     i_sq,
    output logic             o_valid,
    output rsi_pkg::t_result o_res
);
    localparam int CW   = rsi_pkg::CW;
    localparam int T_W  = rsi_pkg::T_W;
    localparam int TS_W = rsi_pkg::TS_W;
    localparam int FB   = rsi_pkg::FB;

    logic           r_valid;
    logic           r_hit;
    logic [T_W-1:0] r_t;
    logic [TS_W-1:0] w_ts;
    logic           w_fits;
    logic [CW-1:0]  w_dist;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    // On a hit b is not positive, so -b is the stored magnitude.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_hit <= i_sq.hit;
            r_t   <= T_W'(i_sq.abs_b) - T_W'(i_sq.root);
        end
    end

    assign w_ts   = r_t[T_W-1:FB];
    assign w_fits = (&w_ts[TS_W-1:CW-1]) || !(|w_ts[TS_W-1:CW-1]);
    assign w_dist = w_fits ? w_ts[CW-1:0]
                  : (w_ts[TS_W-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}});

    assign o_valid        = r_valid;
    assign o_res.hit      = r_hit;
    assign o_res.distance = r_hit ? w_dist : '0;
endmodule

/* tb/tb_rsi_stream_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rsi_stream_if: testbench-side note for the shared stream interface
// The channel interface itself lives with the RTL sources; this file only
// provides a small helper package of test-side constants.
// ----------------------------------------------------------------------------
package tb_rsi_pkg;

    // Latency of the block, and that latency plus margin for draining.
    localparam int PIPE_LAT = 77;
    localparam int DRAIN_CYCLES = PIPE_LAT + 20;

endpackage

/* tb/tb_ray_sphere_intersect.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ray_sphere_intersect: self-checking bench of the ray/sphere block
// Rays stream in from a queue, each result is predicted with exact wide
// integer arithmetic and compared in order with what the block returns,
// under several sphere settings and several idling patterns.
// ----------------------------------------------------------------------------
module tb_ray_sphere_intersect;

    logic i_clk;
    logic i_rst_n;

    rsi_stream_if #(.T(rsi_pkg::t_ray))    ray_if ();
    rsi_stream_if #(.T(rsi_pkg::t_result)) res_if ();
    rsi_stream_if #(.T(rsi_pkg::t_cfg_wr)) cfg_if ();

    ray_sphere_intersect dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ray   (ray_if.sink),
        .o_res   (res_if.source),
        .i_cfg   (cfg_if.sink)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Sphere as the predictor sees it.
    logic signed [rsi_pkg::CW-1:0] sph_cx, sph_cy, sph_cz;
    logic [rsi_pkg::RW-1:0]        sph_radius, sph_scale;

    rsi_pkg::t_ray    ray_queue[$];      // rays waiting to be offered
    rsi_pkg::t_result hit_queue[$];      // predicted results, oldest first
    rsi_pkg::t_cfg_wr cfg_queue[$];      // register writes waiting to be offered

    int  mismatch_count = 0;
    int  rays_sent = 0;
    int  results_seen = 0;
    int  hits_seen = 0;
    int  send_idle_pct = 0;     // percent of cycles the sender holds back
    int  recv_idle_pct = 0;     // percent of cycles the receiver stalls
    logic hold_off = 1'b0;      // long receiver stall, raised by its own process
    longint cycle_count = 0;

    // Exact wide arithmetic: 200 bits is more than any intermediate needs.
    typedef logic signed [199:0] t_wide;

    // Floor square root of a non-negative value, one result bit per step.
    function automatic t_wide floor_sqrt(t_wide v);
        t_wide num, root, bitv;
        num  = v;
        root = '0;
        bitv = t_wide'(1) <<< 196;
        while (bitv != 0 && bitv > num)
            bitv = bitv >>> 2;
        while (bitv != 0) begin
            if (num >= root + bitv) begin
                num  = num - (root + bitv);
                root = (root >>> 1) + bitv;
            end else begin
                root = root >>> 1;
            end
            bitv = bitv >>> 2;
        end
        return root;
    endfunction

    // Predict the intersection of one ray with the current sphere.
    function automatic rsi_pkg::t_result intersect_ray(rsi_pkg::t_ray r);
        t_wide oc_x, oc_y, oc_z, b, q, sr, disc, t, lim_hi, lim_lo;
        rsi_pkg::t_result res;
        oc_x = t_wide'(r.origin_x) - t_wide'(sph_cx);
        oc_y = t_wide'(r.origin_y) - t_wide'(sph_cy);
        oc_z = t_wide'(r.origin_z) - t_wide'(sph_cz);
        b = t_wide'(r.dir_x) * oc_x + t_wide'(r.dir_y) * oc_y
            + t_wide'(r.dir_z) * oc_z;
        q = (oc_x * oc_x + oc_y * oc_y + oc_z * oc_z) <<< (2 * rsi_pkg::FB);
        sr = t_wide'({1'b0, sph_radius}) * t_wide'({1'b0, sph_scale});
        disc = b * b - q + sr * sr;
        res = '0;
        // A negative discriminant or a ray pointing away both count as a miss.
        if (disc < 0 || b > 0)
            return res;
        t = (-b - floor_sqrt(disc)) >>> rsi_pkg::FB;
        lim_hi = t_wide'(32'sh7fff_ffff);
        lim_lo = t_wide'(-64'sd2147483648);
        if (t > lim_hi)
            t = lim_hi;
        if (t < lim_lo)
            t = lim_lo;
        res.hit      = 1'b1;
        res.distance = t[rsi_pkg::CW-1:0];
        return res;
    endfunction

    task automatic report_mismatch(string what, rsi_pkg::t_result got,
                                   rsi_pkg::t_result want);
        $display("mismatch %s: got hit=%0b dist=%0d, expected hit=%0b dist=%0d",
                 what, got.hit, got.distance, want.hit, want.distance);
        mismatch_count++;
    endtask

    // Ray driver: offers rays from the queue and predicts on each transfer.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            ray_if.valid <= 1'b0;
            ray_if.data  <= '0;
        end else begin
            if (ray_if.valid && ray_if.ready) begin
                hit_queue.insert(hit_queue.size(), intersect_ray(ray_if.data));
                rays_sent++;
            end
            // Only move on when the current offer was taken or none stands.
            if (!ray_if.valid || ray_if.ready) begin
                if (ray_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    ray_if.valid <= 1'b1;
                    ray_if.data  <= ray_queue.pop_front();
                end else begin
                    ray_if.valid <= 1'b0;
                end
            end
        end
    end

    // Configuration driver: the block is idle whenever entries are queued here.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_if.valid <= 1'b0;
            cfg_if.data  <= '0;
        end else begin
            if (cfg_if.valid && cfg_if.ready) begin
                case (rsi_pkg::t_reg_idx'(cfg_if.data.index))
                    rsi_pkg::REG_CENTER_X: sph_cx = cfg_if.data.value;
                    rsi_pkg::REG_CENTER_Y: sph_cy = cfg_if.data.value;
                    rsi_pkg::REG_CENTER_Z: sph_cz = cfg_if.data.value;
                    rsi_pkg::REG_RADIUS:   sph_radius = cfg_if.data.value[rsi_pkg::RW-1:0];
                    rsi_pkg::REG_SCALE:    sph_scale = cfg_if.data.value[rsi_pkg::RW-1:0];
                    default: ;
                endcase
            end
            if (!cfg_if.valid || cfg_if.ready) begin
                if (cfg_queue.size() > 0) begin
                    cfg_if.valid <= 1'b1;
                    cfg_if.data  <= cfg_queue.pop_front();
                end else begin
                    cfg_if.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor with its own ready pattern; the long hold-off overrides it.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                results_seen++;
                if (res_if.data.hit)
                    hits_seen++;
                if (hit_queue.size() == 0) begin
                    report_mismatch("unexpected result", res_if.data, '0);
                end else begin
                    rsi_pkg::t_result want;
                    want = hit_queue.pop_front();
                    if (res_if.data.hit !== want.hit)
                        report_mismatch("hit flag", res_if.data, want);
                    else if (res_if.data.distance !== want.distance)
                        report_mismatch("distance", res_if.data, want);
                end
            end
            if (hold_off) begin
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000) begin
            $display("timeout with %0d results outstanding", hit_queue.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic rsi_pkg::t_ray random_ray();
        rsi_pkg::t_ray r;
        int   mode;
        mode = $urandom_range(9);
        if (mode < 2) begin
            // Raw noise in every bit.
            r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        end else begin
            // Rays aimed near the sphere with roughly unit directions.
            r.origin_x = sph_cx + $signed($urandom_range(32'h0200_0000)) - 32'sh0100_0000;
            r.origin_y = sph_cy + $signed($urandom_range(32'h0200_0000)) - 32'sh0100_0000;
            r.origin_z = sph_cz + $signed($urandom_range(32'h0200_0000)) - 32'sh0100_0000;
            r.dir_x = $signed($urandom_range(32'h0002_0000)) - 32'sh0001_0000;
            r.dir_y = $signed($urandom_range(32'h0002_0000)) - 32'sh0001_0000;
            r.dir_z = $signed($urandom_range(32'h0002_0000)) - 32'sh0001_0000;
            // Mostly point back toward the center so hits are common.
            if (mode < 8) begin
                r.dir_x = (r.origin_x > sph_cx) ? -$signed({1'b0, r.dir_x[30:0]} & 32'h1ffff)
                                                : (r.dir_x & 32'h1ffff);
                r.dir_y = (r.origin_y > sph_cy) ? -(r.dir_y & 32'h1ffff) : (r.dir_y & 32'h1ffff);
                r.dir_z = (r.origin_z > sph_cz) ? -(r.dir_z & 32'h1ffff) : (r.dir_z & 32'h1ffff);
            end
        end
        return r;
    endfunction

    task automatic add_ray(rsi_pkg::t_ray r);
        ray_queue.insert(ray_queue.size(), r);
    endtask

    task automatic add_cfg(rsi_pkg::t_reg_idx idx, logic [rsi_pkg::CW-1:0] value);
        rsi_pkg::t_cfg_wr w;
        w.index = idx;
        w.value = value;
        cfg_queue.insert(cfg_queue.size(), w);
    endtask

    task automatic wait_drained();
        while (ray_queue.size() > 0 || ray_if.valid || hit_queue.size() > 0)
            @(posedge i_clk);
        repeat (tb_rsi_pkg::DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_sphere(logic [rsi_pkg::CW-1:0] cx, logic [rsi_pkg::CW-1:0] cy,
                                logic [rsi_pkg::CW-1:0] cz, logic [rsi_pkg::CW-1:0] rad,
                                logic [rsi_pkg::CW-1:0] scl);
        add_cfg(rsi_pkg::REG_CENTER_X, cx);
        add_cfg(rsi_pkg::REG_CENTER_Y, cy);
        add_cfg(rsi_pkg::REG_CENTER_Z, cz);
        add_cfg(rsi_pkg::REG_RADIUS, rad);
        add_cfg(rsi_pkg::REG_SCALE, scl);
        while (cfg_queue.size() > 0 || cfg_if.valid)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic random_phase(int count);
        repeat (count) add_ray(random_ray());
    endtask

    initial begin
        rsi_pkg::t_ray r;
        i_rst_n    = 1'b0;
        sph_cx     = '0;
        sph_cy     = '0;
        sph_cz     = '0;
        sph_radius = rsi_pkg::RADIUS_RST;
        sph_scale  = rsi_pkg::SCALE_RST;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed rays against the reset sphere of radius 100.
        r = '0; r.origin_z = -32'sd200 <<< rsi_pkg::FB; r.dir_z = 32'sd1 <<< rsi_pkg::FB;
        add_ray(r);                                   // straight hit
        r.dir_z = -(32'sd1 <<< rsi_pkg::FB);
        add_ray(r);                                   // pointing away, miss
        r = '0; r.origin_x = 32'sd100 <<< rsi_pkg::FB;
        r.origin_z = -32'sd300 <<< rsi_pkg::FB;
        r.dir_z = 32'sd1 <<< rsi_pkg::FB;
        add_ray(r);                                   // tangent ray
        r = '0; r.dir_x = 32'sd1 <<< rsi_pkg::FB;
        add_ray(r);                                   // origin inside, negative t
        r = '0; r.origin_y = 32'sd500 <<< rsi_pkg::FB; r.dir_x = 32'sd1 <<< rsi_pkg::FB;
        add_ray(r);                                   // clear miss
        r = '0; r.origin_z = -32'sd200 <<< rsi_pkg::FB; r.dir_z = 32'sd3 <<< rsi_pkg::FB;
        add_ray(r);                                   // direction not unit length
        r = {6{32'sh8000_0000}};
        add_ray(r);                                   // most negative everywhere
        r = {6{32'sh7fff_ffff}};
        add_ray(r);                                   // most positive everywhere
        r = '0; r.origin_x = 32'sh8000_0000; r.dir_x = 32'sh7fff_ffff;
        add_ray(r);                                   // extreme origin and direction, hit
        r = '0; r.origin_x = 32'sh7fff_ffff; r.dir_x = 32'sh8000_0000;
        add_ray(r);
        wait_drained();

        // Point sphere and an extreme sphere with saturating distances.
        write_sphere(32'h0001_0000, 32'hffff_0000, 32'h0, 32'h0, 32'h0001_0000);
        r = '0; r.origin_x = 32'sh0001_0000; r.origin_y = 32'shffff_0000;
        r.origin_z = -32'sd5 <<< rsi_pkg::FB; r.dir_z = 32'sd1 <<< rsi_pkg::FB;
        add_ray(r);                                   // through the point
        add_ray(random_ray());
        wait_drained();
        write_sphere(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                     32'hffff_ffff, 32'h7fff_ffff);
        repeat (6) begin
            r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
            add_ray(r);
        end
        wait_drained();

        // Random phase 1: sender idles 30 %, receiver 47 %.
        write_sphere($urandom, $urandom, $urandom, $urandom_range(32'h0100_0000),
                     $urandom_range(32'h0004_0000));
        send_idle_pct = 30; recv_idle_pct = 47;
        random_phase(200);
        wait_drained();

        // Random phase 2: the other way round, on the default-sized sphere.
        write_sphere(32'hff00_0000, 32'h0010_0000, 32'h0, 32'd6553600, 32'd65536);
        send_idle_pct = 47; recv_idle_pct = 30;
        random_phase(200);
        wait_drained();

        // Random phase 3: no idling, then a long receiver hold-off that fills
        // the pipeline and stalls the ray input.
        write_sphere('0, '0, '0, 32'h0000_8000, 32'h0100_0000);
        send_idle_pct = 0; recv_idle_pct = 0;
        random_phase(120);
        random_phase(100);
        fork
            begin
                hold_off <= 1'b1;
                repeat (300) @(posedge i_clk);
                hold_off <= 1'b0;
            end
        join_none
        wait_drained();

        $display("%0d rays sent, %0d results checked (%0d hits) over six sphere settings",
                 rays_sent, results_seen, hits_seen);
        if (mismatch_count == 0 && hit_queue.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d mismatches", mismatch_count);
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
